// File: hdl/afm_pkg.sv
// Shared types and constants of the adaptive median filter.
`default_nettype none
package afm_pkg;

	localparam int PIX_W  = 8;
	localparam int FW_W   = 11;
	localparam int FH_W   = 13;
	localparam int LW_W   = 3;
	localparam int CFG_W  = 13;
	localparam int IDX_W  = 2;
	localparam int ROW_W  = 13;
	localparam int COL_W  = 13;
	localparam int WDT_W  = 14;
	localparam int RAD_W  = 3;
	localparam int KCNT_W = ROW_W + WDT_W;
	localparam int HEIGHT_CAP = 4096;
	localparam int CMDQ_DEPTH = 2;

	localparam logic [IDX_W-1:0] REG_FRAME_WIDTH    = 2'd0;
	localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT   = 2'd1;
	localparam logic [IDX_W-1:0] REG_LARGEST_WINDOW = 2'd2;

	localparam logic FUNC_PIXEL = 1'b0;
	localparam logic FUNC_DRAIN = 1'b1;

	typedef struct packed {
		logic             func;
		logic [PIX_W-1:0] pixel_in;
	} in_item_t;

	typedef struct packed {
		logic [PIX_W-1:0] pixel_out;
		logic             frame_end;
	} out_item_t;

	typedef struct packed {
		logic [WDT_W-1:0] width;
		logic [ROW_W-1:0] height;
		logic [RAD_W-1:0] radius;
	} cfg_eff_t;

	typedef struct packed {
		logic             last;
		logic [ROW_W-1:0] y;
		logic [COL_W-1:0] x;
	} cmd_t;

endpackage
`default_nettype wire

// File: hdl/afm_lines.sv
// Line store ring: one write port, one registered read port.
`default_nettype none
module afm_lines #(
	parameter int AW = 14
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [AW-1:0]            wr_addr,
	input  wire logic [afm_pkg::PIX_W-1:0] wr_data,
	input  wire logic                     rd_en,
	input  wire logic [AW-1:0]            rd_addr,
	output logic      [afm_pkg::PIX_W-1:0] rd_data
);

	logic [afm_pkg::PIX_W-1:0] mem_q [2**AW];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule
`default_nettype wire

// File: hdl/afm_cmdq.sv
// Short command queue between the front and the back.
`default_nettype none
module afm_cmdq (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          wr,
	input  wire afm_pkg::cmd_t wr_cmd,
	input  wire logic          rd,
	output afm_pkg::cmd_t      rd_cmd,
	output logic               q_full,
	output logic               q_empty
);

	localparam int PW = $clog2(afm_pkg::CMDQ_DEPTH);

	afm_pkg::cmd_t   slot_q [afm_pkg::CMDQ_DEPTH];
	logic [PW-1:0]   wptr_q;
	logic [PW-1:0]   rptr_q;
	logic [PW:0]     count_q;

	assign q_full  = (count_q == (PW+1)'(afm_pkg::CMDQ_DEPTH));
	assign q_empty = (count_q == '0);
	assign rd_cmd  = slot_q[rptr_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			slot_q[wptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (wr) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (rd) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (wr && !rd) begin
				count_q <= count_q + 1'b1;
			end else if (rd && !wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// File: hdl/afm_front.sv
// Front: accepts items, writes the line store, issues output commands.
`default_nettype none
module afm_front #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_WINDOW = 7
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire afm_pkg::cfg_eff_t eff,
	input  wire logic              restart,
	input  wire logic              accept,
	input  wire afm_pkg::in_item_t item,
	output logic                   wr_en,
	output logic [$clog2(2*MAX_WINDOW)+$clog2(MAX_WIDTH)-1:0] wr_addr,
	output logic [afm_pkg::PIX_W-1:0] wr_data,
	output logic                   cmd_push,
	output afm_pkg::cmd_t          cmd,
	output logic                   at_start
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RB = $clog2(2*MAX_WINDOW);

	logic [afm_pkg::COL_W-1:0]  in_col_q;
	logic [afm_pkg::ROW_W-1:0]  in_row_q;
	logic [afm_pkg::KCNT_W-1:0] kcnt_q;
	logic [afm_pkg::COL_W-1:0]  out_x_q;
	logic [afm_pkg::ROW_W-1:0]  out_y_q;

	logic [afm_pkg::KCNT_W-1:0] lag;
	logic [afm_pkg::WDT_W-1:0]  wm1;
	logic [afm_pkg::ROW_W-1:0]  hm1;
	logic                       done;
	logic                       pix_write;
	logic                       emit;
	logic                       last;
	logic                       col_wrap;

	assign lag = afm_pkg::KCNT_W'(eff.radius) * afm_pkg::KCNT_W'(eff.width)
		+ afm_pkg::KCNT_W'(eff.radius);
	assign wm1 = eff.width - 1'b1;
	assign hm1 = eff.height - 1'b1;
	assign done = (in_row_q >= eff.height);
	assign pix_write = (item.func == afm_pkg::FUNC_PIXEL) && !done;
	assign emit = (pix_write && (kcnt_q >= lag)) || done;
	assign last = ({1'b0, out_x_q} == wm1) && (out_y_q == hm1);
	assign col_wrap = ({1'b0, in_col_q} + 1'b1) >= eff.width;

	assign wr_en    = accept && pix_write;
	assign wr_addr  = {in_row_q[RB-1:0], in_col_q[CW-1:0]};
	assign wr_data  = item.pixel_in;
	assign cmd_push = accept && emit;
	assign cmd      = '{last: last, y: out_y_q, x: out_x_q};
	assign at_start = (in_row_q == '0) && (in_col_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q <= '0;
			in_row_q <= '0;
			kcnt_q   <= '0;
			out_x_q  <= '0;
			out_y_q  <= '0;
		end else if (restart) begin
			in_col_q <= '0;
			in_row_q <= '0;
			kcnt_q   <= '0;
			out_x_q  <= '0;
			out_y_q  <= '0;
		end else if (accept) begin
			if (pix_write) begin
				kcnt_q <= kcnt_q + 1'b1;
				if (col_wrap) begin
					in_col_q <= '0;
					in_row_q <= in_row_q + 1'b1;
				end else begin
					in_col_q <= in_col_q + 1'b1;
				end
			end
			if (emit) begin
				if (last) begin
					in_col_q <= '0;
					in_row_q <= '0;
					kcnt_q   <= '0;
					out_x_q  <= '0;
					out_y_q  <= '0;
				end else if ({1'b0, out_x_q} == wm1) begin
					out_x_q <= '0;
					out_y_q <= out_y_q + 1'b1;
				end else begin
					out_x_q <= out_x_q + 1'b1;
				end
			end
		end
	end

endmodule
`default_nettype wire

// File: hdl/afm_back.sv
// Back: bitwise rank search over the window sizes, decision, result register.
`default_nettype none
module afm_back #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_WINDOW = 7
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire afm_pkg::cfg_eff_t eff,
	input  wire logic              cmd_valid,
	input  wire afm_pkg::cmd_t     cmd,
	output logic                   cmd_take,
	output logic                   rd_en,
	output logic [$clog2(2*MAX_WINDOW)+$clog2(MAX_WIDTH)-1:0] rd_addr,
	input  wire logic [afm_pkg::PIX_W-1:0] rd_data,
	input  wire logic              pop,
	output logic                   res_valid,
	output afm_pkg::out_item_t     res,
	output logic                   busy
);

	localparam int CW    = $clog2(MAX_WIDTH);
	localparam int RB    = $clog2(2*MAX_WINDOW);
	localparam int NS    = (MAX_WINDOW - 1) / 2;
	localparam int CNT_W = $clog2(MAX_WINDOW*MAX_WINDOW + 1);
	localparam int OW    = afm_pkg::RAD_W + 1;
	localparam int YW    = afm_pkg::ROW_W + 2;
	localparam int XW    = afm_pkg::COL_W + 2;
	localparam int PW    = afm_pkg::PIX_W;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SWEEP = 3'd1;
	localparam logic [2:0] ST_WAIT  = 3'd2;
	localparam logic [2:0] ST_STEP  = 3'd3;
	localparam logic [2:0] ST_DONE  = 3'd4;

	logic [2:0]            state_q;
	afm_pkg::cmd_t         cmd_q;
	logic [2:0]            pass_q;
	logic signed [OW-1:0]  dy_q;
	logic signed [OW-1:0]  dx_q;
	logic [PW-1:0]         prefix_q [NS];
	logic [PW-1:0]         min_q    [NS];
	logic [PW-1:0]         max_q    [NS];
	logic [CNT_W-1:0]      cnt_q    [NS];
	logic [PW-1:0]         centre_q;
	logic                  res_valid_q;
	afm_pkg::out_item_t    res_q;

	logic                       v_s1;
	logic [afm_pkg::RAD_W-1:0]  maxabs_s1;
	logic                       centre_s1;

	logic signed [OW-1:0]  r_s;
	logic signed [OW-1:0]  ady;
	logic signed [OW-1:0]  adx;
	logic signed [YW-1:0]  yy;
	logic signed [XW-1:0]  xx;
	logic [afm_pkg::ROW_W-1:0] row;
	logic [afm_pkg::COL_W-1:0] col;
	logic [PW-1:0]         bit_mask;
	logic [PW-1:0]         chosen;

	assign r_s = signed'({1'b0, eff.radius});
	assign ady = (dy_q < 0) ? -dy_q : dy_q;
	assign adx = (dx_q < 0) ? -dx_q : dx_q;
	assign bit_mask = 8'h80 >> pass_q;

	// Clamped window coordinates replicate the border pixels.
	always_comb begin
		yy = signed'({2'b00, cmd_q.y}) + YW'(dy_q);
		xx = signed'({2'b00, cmd_q.x}) + XW'(dx_q);
		if (yy < 0) begin
			row = '0;
		end else if (yy > signed'({2'b00, eff.height - 1'b1})) begin
			row = eff.height - 1'b1;
		end else begin
			row = yy[afm_pkg::ROW_W-1:0];
		end
		if (xx < 0) begin
			col = '0;
		end else if (xx > signed'({1'b0, eff.width - 1'b1})) begin
			col = afm_pkg::COL_W'(eff.width - 1'b1);
		end else begin
			col = xx[afm_pkg::COL_W-1:0];
		end
	end

	assign rd_en   = (state_q == ST_SWEEP);
	assign rd_addr = {row[RB-1:0], col[CW-1:0]};
	assign cmd_take = (state_q == ST_IDLE) && cmd_valid;

	// The line store is read only while sweeping and in the cycles that drain the read.
	assign busy = (state_q == ST_SWEEP) || (state_q == ST_WAIT) || (state_q == ST_STEP);

	// The first size whose median is not an extreme decides the output.
	always_comb begin
		chosen = prefix_q[0];
		for (int i = 0; i < NS; i++) begin
			if (afm_pkg::RAD_W'(i + 1) == eff.radius) begin
				chosen = prefix_q[i];
			end
		end
		for (int i = NS - 1; i >= 0; i--) begin
			if ((afm_pkg::RAD_W'(i + 1) <= eff.radius) &&
				(prefix_q[i] > min_q[i]) && (prefix_q[i] < max_q[i])) begin
				chosen = ((centre_q > min_q[i]) && (centre_q < max_q[i]))
					? centre_q : prefix_q[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && cmd_valid) begin
			cmd_q <= cmd;
			for (int i = 0; i < NS; i++) begin
				prefix_q[i] <= '0;
				min_q[i]    <= '1;
				max_q[i]    <= '0;
				cnt_q[i]    <= '0;
			end
		end else if (state_q == ST_STEP) begin
			for (int i = 0; i < NS; i++) begin
				if (cnt_q[i] <= CNT_W'(((2*i + 3) * (2*i + 3)) >> 1)) begin
					prefix_q[i] <= prefix_q[i] | bit_mask;
				end
				cnt_q[i] <= '0;
			end
		end else if (v_s1) begin
			for (int i = 0; i < NS; i++) begin
				if (maxabs_s1 <= afm_pkg::RAD_W'(i + 1)) begin
					if (rd_data < (prefix_q[i] | bit_mask)) begin
						cnt_q[i] <= cnt_q[i] + 1'b1;
					end
					if (pass_q == '0) begin
						if (rd_data < min_q[i]) begin
							min_q[i] <= rd_data;
						end
						if (rd_data > max_q[i]) begin
							max_q[i] <= rd_data;
						end
					end
				end
			end
			if (centre_s1) begin
				centre_q <= rd_data;
			end
		end
		maxabs_s1 <= (ady > adx) ? ady[afm_pkg::RAD_W-1:0] : adx[afm_pkg::RAD_W-1:0];
		centre_s1 <= (dy_q == 0) && (dx_q == 0);
		if (state_q == ST_DONE && !res_valid_q) begin
			res_q <= '{pixel_out: chosen, frame_end: cmd_q.last};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pass_q      <= '0;
			dy_q        <= '0;
			dx_q        <= '0;
			v_s1        <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			v_s1 <= (state_q == ST_SWEEP);
			if (pop && res_valid_q) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						pass_q  <= '0;
						dy_q    <= -r_s;
						dx_q    <= -r_s;
						state_q <= ST_SWEEP;
					end
				end
				ST_SWEEP: begin
					if (dx_q == r_s) begin
						dx_q <= -r_s;
						if (dy_q == r_s) begin
							state_q <= ST_WAIT;
						end else begin
							dy_q <= dy_q + 1'b1;
						end
					end else begin
						dx_q <= dx_q + 1'b1;
					end
				end
				ST_WAIT: begin
					state_q <= ST_STEP;
				end
				ST_STEP: begin
					if (pass_q == 3'd7) begin
						state_q <= ST_DONE;
					end else begin
						pass_q  <= pass_q + 1'b1;
						dy_q    <= -r_s;
						dx_q    <= -r_s;
						state_q <= ST_SWEEP;
					end
				end
				ST_DONE: begin
					if (!res_valid_q) begin
						res_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule
`default_nettype wire

// File: hdl/adaptive_median_filter.sv
// Top level of the adaptive median filter: configuration, front, queue, back.
// An input item is taken while the command queue has room; the first
// pixel of a frame also waits until the back has stopped reading the previous frame.
// The back works on one result at a time, sweeping the (2R+1)^2 window once per
// result bit (R = half the largest window); pixel R*W+R (from zero) asks first.
// Reset clears counters, queue and result register; the line store is not cleared.
`default_nettype none
module adaptive_median_filter #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_WINDOW = 7
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        push,
	output logic                             full,
	input  wire afm_pkg::in_item_t           item,
	output logic                             empty,
	input  wire logic                        pop,
	output afm_pkg::out_item_t               result,
	input  wire logic                        cfg_we,
	input  wire logic [afm_pkg::IDX_W-1:0]   cfg_index,
	input  wire logic [afm_pkg::CFG_W-1:0]   cfg_data
);

	localparam int AW = $clog2(2*MAX_WINDOW) + $clog2(MAX_WIDTH);
	localparam int NS = (MAX_WINDOW - 1) / 2;

	// Configuration registers, as written.
	logic [afm_pkg::FW_W-1:0] frame_width_q;
	logic [afm_pkg::FH_W-1:0] frame_height_q;
	logic [afm_pkg::LW_W-1:0] largest_window_q;

	afm_pkg::cfg_eff_t eff;
	logic              restart;
	logic              accept;
	logic              wr_en;
	logic [AW-1:0]     wr_addr;
	logic [afm_pkg::PIX_W-1:0] wr_data;
	logic              rd_en;
	logic [AW-1:0]     rd_addr;
	logic [afm_pkg::PIX_W-1:0] rd_data;
	logic              cmd_push;
	afm_pkg::cmd_t     cmd_in;
	afm_pkg::cmd_t     cmd_out;
	logic              cmd_take;
	logic              q_full;
	logic              q_empty;
	logic              res_valid;
	logic              at_start;
	logic              back_busy;

	// Any write to a known register restarts the frame.
	assign restart = cfg_we && ((cfg_index == afm_pkg::REG_FRAME_WIDTH) ||
		(cfg_index == afm_pkg::REG_FRAME_HEIGHT) ||
		(cfg_index == afm_pkg::REG_LARGEST_WINDOW));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q    <= afm_pkg::FW_W'(1024);
			frame_height_q   <= afm_pkg::FH_W'(1024);
			largest_window_q <= afm_pkg::LW_W'(7);
		end else if (cfg_we) begin
			case (cfg_index)
				afm_pkg::REG_FRAME_WIDTH:    frame_width_q    <= cfg_data[afm_pkg::FW_W-1:0];
				afm_pkg::REG_FRAME_HEIGHT:   frame_height_q   <= cfg_data[afm_pkg::FH_W-1:0];
				afm_pkg::REG_LARGEST_WINDOW: largest_window_q <= cfg_data[afm_pkg::LW_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Out-of-range settings are folded into their usable range here, so the
	// rest of the design only ever sees legal width, height and radius.
	always_comb begin
		if (frame_width_q == '0) begin
			eff.width = afm_pkg::WDT_W'(1);
		end else if (32'(frame_width_q) > MAX_WIDTH) begin
			eff.width = afm_pkg::WDT_W'(MAX_WIDTH);
		end else begin
			eff.width = afm_pkg::WDT_W'(frame_width_q);
		end
		if (frame_height_q == '0) begin
			eff.height = afm_pkg::ROW_W'(1);
		end else if (frame_height_q > afm_pkg::FH_W'(afm_pkg::HEIGHT_CAP)) begin
			eff.height = afm_pkg::ROW_W'(afm_pkg::HEIGHT_CAP);
		end else begin
			eff.height = frame_height_q;
		end
		// Even sides round down to the odd side below: radius is (side-1)/2.
		if (largest_window_q < afm_pkg::LW_W'(3)) begin
			eff.radius = afm_pkg::RAD_W'(1);
		end else begin
			eff.radius = afm_pkg::RAD_W'((largest_window_q - 1'b1) >> 1);
		end
		if (32'(eff.radius) > NS) begin
			eff.radius = afm_pkg::RAD_W'(NS);
		end
	end

	// A new frame reuses the ring slots of the rows that the previous frame's
	// last outputs still read, so its first pixel waits until every command of
	// that frame has left the queue and the back has finished its reads.
	assign full   = q_full || (at_start && (!q_empty || back_busy));
	assign accept = push && !full;

	afm_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_WINDOW(MAX_WINDOW)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.eff      (eff),
		.restart  (restart),
		.accept   (accept),
		.item     (item),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data),
		.cmd_push (cmd_push),
		.cmd      (cmd_in),
		.at_start (at_start)
	);

	// The line ring holds at least twice the largest window in rows, which
	// covers the rows the back reads plus the few the front may run ahead.
	afm_lines #(.AW(AW)) u_lines (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	afm_cmdq u_cmdq (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (cmd_push),
		.wr_cmd  (cmd_in),
		.rd      (cmd_take),
		.rd_cmd  (cmd_out),
		.q_full  (q_full),
		.q_empty (q_empty)
	);

	afm_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_WINDOW(MAX_WINDOW)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.eff       (eff),
		.cmd_valid (!q_empty),
		.cmd       (cmd_out),
		.cmd_take  (cmd_take),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data),
		.pop       (pop),
		.res_valid (res_valid),
		.res       (result),
		.busy      (back_busy)
	);

	assign empty = !res_valid;

endmodule
`default_nettype wire

// File: hdl/afm_checker.sv
// Port-level checks of the adaptive median filter and their binding.
`default_nettype none
module afm_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               empty,
	input wire logic               pop,
	input wire afm_pkg::out_item_t result
);

	// No result is shown while reset is applied.
	a_reset_empty: assert property (@(posedge clk) !arst_n |-> empty)
		else $error("result shown during reset");

	// A waiting result holds until it is taken.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(result)))
		else $error("waiting result changed");

	// The back sets a new result only after the taken one has cleared, so a taken result is never followed at once.
	a_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && pop) |=> empty)
		else $error("result followed in the next cycle");

endmodule

bind adaptive_median_filter afm_checker u_afm_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.empty  (empty),
	.pop    (pop),
	.result (result)
);
`default_nettype wire

// File: sim/tb_adaptive_median_filter.sv
// Self-checking testbench for the adaptive median filter.
module tb_adaptive_median_filter;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_WINDOW = 7;
	localparam int RING_ROWS  = 2 * MAX_WINDOW;
	localparam int RAND_ITEMS = 800;
	// Settle time, generous against the slowest result at 7x7.
	localparam int SETTLE_CYCLES = 1000;

	logic                          clk;
	logic                          arst_n;
	logic                          push;
	logic                          full;
	afm_pkg::in_item_t             in_item;
	logic                          empty;
	logic                          pop;
	afm_pkg::out_item_t            out_item;
	logic                          cfg_we;
	logic [afm_pkg::IDX_W-1:0]     cfg_index;
	logic [afm_pkg::CFG_W-1:0]     cfg_data;

	adaptive_median_filter #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_WINDOW(MAX_WINDOW)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.item     (in_item),
		.empty    (empty),
		.pop      (pop),
		.result   (out_item),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// Clock: period of 20 time units.
	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// Items waiting to be sent and filtered pixels waiting to come back.
	afm_pkg::in_item_t  pending_items[$];
	afm_pkg::out_item_t filtered_q[$];

	int mismatches;
	int pixels_checked;
	int items_queued;
	int frames_run;

	// Shadow of the filter: line store, raster counters and register values.
	logic [afm_pkg::PIX_W-1:0] line_mem [0:RING_ROWS*MAX_WIDTH-1];
	int unsigned col_in, row_in, out_pos;
	int unsigned width_reg, height_reg, window_reg;

	function automatic int unsigned width_eff();
		int unsigned w;
		w = width_reg;
		if (w < 1) w = 1;
		if (w > MAX_WIDTH) w = MAX_WIDTH;
		return w;
	endfunction

	function automatic int unsigned height_eff();
		int unsigned h;
		h = height_reg;
		if (h < 1) h = 1;
		if (h > afm_pkg::HEIGHT_CAP) h = afm_pkg::HEIGHT_CAP;
		return h;
	endfunction

	// Largest odd window side actually used.
	function automatic int window_eff();
		int s;
		s = window_reg;
		if (s < 3) s = 3;
		if (s % 2 == 0) s = s - 1;
		if (s > MAX_WINDOW) s = MAX_WINDOW;
		return s;
	endfunction

	// Border pixels are replicated outward.
	function automatic logic [afm_pkg::PIX_W-1:0] neighbor(int r, int c, int w, int h);
		if (r < 0) r = 0;
		if (r > h - 1) r = h - 1;
		if (c < 0) c = 0;
		if (c > w - 1) c = w - 1;
		return line_mem[(r % RING_ROWS) * MAX_WIDTH + c];
	endfunction

	// Grows the window until its median is strictly inside its range.
	function automatic logic [afm_pkg::PIX_W-1:0] median_pick(int y, int x, int w, int h);
		logic [afm_pkg::PIX_W-1:0] sorted [0:48];
		logic [afm_pkg::PIX_W-1:0] v;
		int top, centre, last, half, n, i, mn, mx, md;
		top = window_eff();
		centre = neighbor(y, x, w, h);
		last = centre;
		for (int s = 3; s <= top; s += 2) begin
			half = s / 2;
			n = 0;
			for (int dy = -half; dy <= half; dy++) begin
				for (int dx = -half; dx <= half; dx++) begin
					v = neighbor(y + dy, x + dx, w, h);
					i = n;
					while (i > 0 && sorted[i-1] > v) begin
						sorted[i] = sorted[i-1];
						i--;
					end
					sorted[i] = v;
					n++;
				end
			end
			mn = sorted[0];
			mx = sorted[n-1];
			md = sorted[n/2];
			last = md;
			if (md > mn && md < mx)
				return afm_pkg::PIX_W'((centre > mn && centre < mx) ? centre : md);
		end
		return afm_pkg::PIX_W'(last);
	endfunction

	// Produces the next filtered pixel and wraps the frame after the last one.
	task automatic release_pixel(int unsigned w, int unsigned h);
		afm_pkg::out_item_t o;
		o.pixel_out = median_pick(int'(out_pos / w), int'(out_pos % w), int'(w), int'(h));
		out_pos++;
		o.frame_end = (out_pos >= w * h);
		if (o.frame_end) begin
			col_in = 0;
			row_in = 0;
			out_pos = 0;
		end
		filtered_q = {filtered_q, o};
	endtask

	// Advances the shadow state by one accepted item.
	task automatic track_item(afm_pkg::in_item_t it);
		int unsigned w, h, r, lag, k, c;
		bit done;
		w = width_eff();
		h = height_eff();
		done = (row_in >= h);
		if (it.func == afm_pkg::FUNC_PIXEL && !done) begin
			r = window_eff() / 2;
			lag = r * w + r;
			c = (col_in >= MAX_WIDTH) ? MAX_WIDTH - 1 : col_in;
			line_mem[(row_in % RING_ROWS) * MAX_WIDTH + c] = it.pixel_in;
			k = row_in * w + col_in;
			col_in++;
			if (col_in >= w) begin
				col_in = 0;
				row_in++;
			end
			if (k >= lag && out_pos < w * h)
				release_pixel(w, h);
		end else if (done && out_pos < w * h) begin
			// A drain, or a pixel arriving once the frame's input is complete.
			release_pixel(w, h);
		end
	endtask

	task automatic report(string what, int got, int want);
		$display("MISMATCH at %0t: %s got %0d expected %0d", $realtime, what, got, want);
		mismatches++;
	endtask

	// Sender: bursts of random length separated by random gaps.
	int burst_left;
	int gap_left;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push <= 1'b0;
			in_item <= '0;
			burst_left = 0;
			gap_left = 0;
		end else begin : sender
			bit hold;
			hold = push && full;
			if (push && !full)
				track_item(in_item);
			if (!hold) begin
				if (burst_left == 0) begin
					// Now and then a long stretch with no gaps at all.
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
					burst_left = $urandom_range(1, 48);
				end
				if (gap_left != 0) begin
					gap_left--;
					push <= 1'b0;
				end else if (pending_items.size() != 0) begin
					in_item <= pending_items.pop_front();
					push <= 1'b1;
					burst_left--;
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	// Receiver: pops under a stall mode that is drawn anew at random.
	int pop_mode;
	int pop_phase;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop <= 1'b0;
			pop_mode = 0;
			pop_phase = 0;
		end else begin : receiver
			afm_pkg::out_item_t want;
			if (pop && !empty) begin
				if (filtered_q.size() == 0) begin
					report("unexpected pixel_out", out_item.pixel_out, -1);
				end else begin
					want = filtered_q.pop_front();
					if (out_item.pixel_out !== want.pixel_out)
						report("pixel_out", out_item.pixel_out, want.pixel_out);
					if (out_item.frame_end !== want.frame_end)
						report("frame_end", out_item.frame_end, want.frame_end);
					pixels_checked++;
				end
			end
			pop_phase++;
			if (pop_phase % 64 == 0)
				pop_mode = $urandom_range(0, 3);
			case (pop_mode)
				0: pop <= 1'b1;
				1: pop <= ($urandom_range(0, 1) != 0);
				2: pop <= (pop_phase % 4 == 0);
				default: pop <= ($urandom_range(0, 7) == 0);
			endcase
		end
	end

	task automatic queue_item(logic func, logic [afm_pkg::PIX_W-1:0] pix);
		afm_pkg::in_item_t it;
		it.func = func;
		it.pixel_in = pix;
		pending_items = {pending_items, it};
		items_queued++;
	endtask

	// Waits until every item went in and every pixel came out, then lets the
	// filter finish any work that yields no result.
	task automatic settle();
		while (pending_items.size() != 0 || push || filtered_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Register writes must happen only while the filter is idle; this task does not check it.
	task automatic write_reg(logic [afm_pkg::IDX_W-1:0] idx, int unsigned value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= afm_pkg::CFG_W'(value);
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			afm_pkg::REG_FRAME_WIDTH:    width_reg = value & 'h7FF;
			afm_pkg::REG_FRAME_HEIGHT:   height_reg = value & 'h1FFF;
			afm_pkg::REG_LARGEST_WINDOW: window_reg = value & 'h7;
			default: ;
		endcase
		col_in = 0;
		row_in = 0;
		out_pos = 0;
	endtask

	// Pixel content: plain noise, flat field with impulse noise, or extremes.
	function automatic logic [afm_pkg::PIX_W-1:0] make_pixel(int style);
		case (style)
			0: return afm_pkg::PIX_W'($urandom_range(0, 255));
			1: begin
				if ($urandom_range(0, 4) == 0)
					return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
				return afm_pkg::PIX_W'(100 + $urandom_range(0, 3));
			end
			default: return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
		endcase
	endfunction

	// One frame: configure, send pixels (all or a part), then drain items.
	// Some drains are sent as pixel items, which the filter must treat alike.
	task automatic run_frame(int unsigned w, int unsigned h, int unsigned lw,
			int npix, int style);
		int total, r, lag;
		write_reg(afm_pkg::REG_FRAME_WIDTH, w);
		write_reg(afm_pkg::REG_FRAME_HEIGHT, h);
		write_reg(afm_pkg::REG_LARGEST_WINDOW, lw);
		total = width_eff() * height_eff();
		r = window_eff() / 2;
		lag = r * width_eff() + r;
		if (npix < 0 || npix >= total) begin
			npix = total;
			// An early drain is ignored while the frame input is still open.
			if (total > 1 && $urandom_range(0, 3) == 0)
				queue_item(afm_pkg::FUNC_DRAIN, afm_pkg::PIX_W'($urandom_range(0, 255)));
		end
		for (int i = 0; i < npix; i++)
			queue_item(afm_pkg::FUNC_PIXEL, make_pixel(style));
		if (npix == total) begin
			for (int i = 0; i < lag; i++)
				queue_item(($urandom_range(0, 3) == 0) ? afm_pkg::FUNC_PIXEL
					: afm_pkg::FUNC_DRAIN, afm_pkg::PIX_W'($urandom_range(0, 255)));
			// Drains after the frame closed yield nothing.
			for (int i = $urandom_range(0, 2); i > 0; i--)
				queue_item(afm_pkg::FUNC_DRAIN, afm_pkg::PIX_W'($urandom_range(0, 255)));
		end
		frames_run++;
		settle();
	endtask

	initial begin : stimulus
		int base;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		mismatches = 0;
		pixels_checked = 0;
		items_queued = 0;
		frames_run = 0;
		col_in = 0;
		row_in = 0;
		out_pos = 0;
		width_reg = 1024;
		height_reg = 1024;
		window_reg = 7;
		for (int i = 0; i < RING_ROWS * MAX_WIDTH; i++)
			line_mem[i] = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset defaults: a few pixels and an early drain, nothing comes out.
		queue_item(afm_pkg::FUNC_PIXEL, 8'h00);
		queue_item(afm_pkg::FUNC_PIXEL, 8'hFF);
		queue_item(afm_pkg::FUNC_DRAIN, 8'h5A);
		settle();

		// Zero registers act as 1x1 frame and 3x3 window.
		run_frame(0, 0, 0, -1, 2);
		run_frame(3, 3, 7, -1, 2);
		run_frame(4, 3, 4, -1, 1);
		run_frame(5, 4, 6, -1, 0);
		run_frame(2, 5, 1, -1, 1);
		run_frame(1, 2, 5, -1, 2);
		// Oversized registers, cut short by the next write.
		run_frame(2047, 4096, 5, 6, 0);
		run_frame(1, 8191, 2, 10, 1);
		run_frame(1025, 1, 3, 40, 0);
		// Widest row, cut short before any output is due.
		run_frame(1024, 1, 3, 300, 0);

		base = items_queued;
		while (items_queued - base < RAND_ITEMS) begin : random_frames
			int unsigned w, h;
			w = ($urandom_range(0, 15) == 0) ? $urandom_range(13, 40)
				: $urandom_range(1, 12);
			h = $urandom_range(1, 6);
			run_frame(w, h, $urandom_range(0, 7),
				($urandom_range(0, 7) == 0) ? int'($urandom_range(0, w * h)) : -1,
				int'($urandom_range(0, 2)));
		end

		$display("Covered %0d frames and %0d items; %0d filtered pixels checked.",
			frames_run, items_queued, pixels_checked);
		if (mismatches == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	initial begin
		#100000000;
		$display("Timed out with %0d pixels outstanding.", filtered_q.size());
		$display("end of test: mismatches");
		$finish;
	end

endmodule

// File: files.f
hdl/afm_pkg.sv
hdl/afm_lines.sv
hdl/afm_cmdq.sv
hdl/afm_front.sv
hdl/afm_back.sv
hdl/adaptive_median_filter.sv
hdl/afm_checker.sv
sim/tb_adaptive_median_filter.sv
